FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the way tag store
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/wctag_pkg.sv
// ----------------------------------------------------------------------------
// wctag_pkg
// shared constants, codes and types of the write-back way tag store
// ----------------------------------------------------------------------------
package wctag_pkg;

   // geometry
   localparam int INDEX_BITS = 8;
   localparam int ADDR_BITS  = 32;
   localparam int LINES      = 1 << INDEX_BITS;
   localparam int TAG_BITS   = ADDR_BITS - INDEX_BITS;
   localparam int AGE_BITS   = 4;

   // port widths
   localparam int OP_BITS        = 3;
   localparam int IN_ADDR_BITS   = 32;
   localparam int STATUS_BITS    = 2;
   localparam int OUT_ADDR_BITS  = 32;
   localparam int OUT_TAG_BITS   = 24;
   localparam int OFFSET_BITS    = 5;
   localparam int CNT_BITS       = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   // largest age counter width in use
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(AGE_BITS);

   // configuration reset values
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET  = OFFSET_BITS'(6);
   localparam logic [CNT_BITS-1:0]    COUNTER_RESET = CNT_BITS'(2);

   // queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic [OP_BITS-1:0] OP_READ  = OP_BITS'(0);
   localparam logic [OP_BITS-1:0] OP_WRITE = OP_BITS'(1);
   localparam logic [OP_BITS-1:0] OP_FILL  = OP_BITS'(2);
   localparam logic [OP_BITS-1:0] OP_FLUSH = OP_BITS'(3);
   localparam logic [OP_BITS-1:0] OP_AGE   = OP_BITS'(4);

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_HIT       = STATUS_BITS'(0);
   localparam logic [STATUS_BITS-1:0] STATUS_MISS      = STATUS_BITS'(1);
   localparam logic [STATUS_BITS-1:0] STATUS_WRITEBACK = STATUS_BITS'(2);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_BITS  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNTER_BITS = CSR_INDEX_BITS'(1);

   // decoded request kind
   typedef enum logic [2:0] {
      KIND_READ,
      KIND_WRITE,
      KIND_FILL,
      KIND_FLUSH,
      KIND_AGE,
      KIND_OTHER
   } kind_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type              kind;
      logic [INDEX_BITS-1:0] line;
      logic [TAG_BITS-1:0]   tag;
      logic                  fill_dirty;
      logic [AGE_BITS-1:0]   fill_age;
   } item_type;

   // queue status seen by front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // one word of the tag memory
   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                dirty;
      logic [AGE_BITS-1:0] age;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

FILE: src/wctag_ram.sv
// ----------------------------------------------------------------------------
// wctag_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wctag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/wctag_front.sv
// ----------------------------------------------------------------------------
// wctag_front
// takes requests and configuration writes, splits the address, classifies
// ----------------------------------------------------------------------------
module wctag_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [wctag_pkg::OP_BITS-1:0]         req_operation,
   input  logic [wctag_pkg::IN_ADDR_BITS-1:0]    req_address,
   input  logic                                  req_fill_dirty,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wctag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wctag_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wctag_pkg::queue_status_type           q_status,
   output logic                                  push,
   output wctag_pkg::item_type                   push_item
);
   import wctag_pkg::*;

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [CNT_BITS-1:0]    counter_ff, counter_in;
   logic [ADDR_BITS-1:0]   addr_used;
   logic [ADDR_BITS-1:0]   addr_shifted;
   logic [CNT_BITS-1:0]    cnt_clamped;
   logic [AGE_BITS:0]      age_span;
   item_type               item;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      offset_in  = offset_ff;
      counter_in = counter_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_BITS:  offset_in  = csr_wdata[OFFSET_BITS-1:0];
            CSR_COUNTER_BITS: counter_in = csr_wdata[CNT_BITS-1:0];
            default:          offset_in  = offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= OFFSET_RESET;
         counter_ff <= COUNTER_RESET;
      end else begin
         offset_ff  <= offset_in;
         counter_ff <= counter_in;
      end
   end

   // address split for lookups
   assign addr_used    = req_address[ADDR_BITS-1:0];
   assign addr_shifted = addr_used >> offset_ff;

   // age loaded on fill: all ones in the clamped counter width
   assign cnt_clamped = (counter_ff > CNT_MAX) ? CNT_MAX : counter_ff;
   assign age_span    = (AGE_BITS+1)'(1) << cnt_clamped;

   // classify the request
   always_comb begin
      item.line       = addr_used[INDEX_BITS-1:0];
      item.tag        = addr_used[ADDR_BITS-1:INDEX_BITS];
      item.fill_dirty = req_fill_dirty;
      item.fill_age   = AGE_BITS'(age_span - (AGE_BITS+1)'(1));
      case (req_operation)
         OP_READ:  item.kind = KIND_READ;
         OP_WRITE: item.kind = KIND_WRITE;
         OP_FILL:  item.kind = KIND_FILL;
         OP_FLUSH: item.kind = KIND_FLUSH;
         OP_AGE:   item.kind = KIND_AGE;
         default:  item.kind = KIND_OTHER;
      endcase
      if (item.kind == KIND_READ || item.kind == KIND_WRITE) begin
         item.line = addr_shifted[INDEX_BITS-1:0];
         item.tag  = addr_shifted[ADDR_BITS-1:INDEX_BITS];
      end
   end

   // request handshake toward the queue
   assign busy      = q_status.full;
   assign push      = start && !q_status.full;
   assign push_item = item;

endmodule

FILE: src/wctag_queue.sv
// ----------------------------------------------------------------------------
// wctag_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wctag_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  wctag_pkg::item_type          push_item,
   input  logic                         pop,
   output wctag_pkg::item_type          head,
   output wctag_pkg::queue_status_type  q_status
);
   import wctag_pkg::*;

   item_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head               = slot_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));

   // checks
   `ASSERT_IMPLIES(a_pop_not_empty, clock, reset, pop, count_ff != '0)
   `ASSERT_IMPLIES(a_push_has_room, clock, reset, push, !q_status.full || pop)

endmodule

FILE: src/wctag_back.sv
// ----------------------------------------------------------------------------
// wctag_back
// executes queued requests against the tag memory and drives results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wctag_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wctag_pkg::item_type                   head,
   input  wctag_pkg::queue_status_type           q_status,
   output logic                                  pop,
   output logic                                  rsp_valid,
   output logic [wctag_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [wctag_pkg::OUT_ADDR_BITS-1:0]   rsp_victim_page_address,
   output logic                                  rsp_victim_dirty,
   output logic                                  rsp_line_valid,
   output logic                                  rsp_line_dirty,
   output logic [wctag_pkg::AGE_BITS-1:0]        rsp_line_age,
   output logic [wctag_pkg::OUT_TAG_BITS-1:0]    rsp_line_tag
);
   import wctag_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH_SCAN,
      ST_FLUSH_CHECK
   } state_type;

   state_type              state_ff, state_in;
   item_type               item_ff, item_in;
   logic [INDEX_BITS-1:0]  scan_ff, scan_in;
   logic [LINES-1:0]       valid_ff, valid_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic [OUT_ADDR_BITS-1:0] victim_ff, victim_in;
   logic                     vdirty_ff, vdirty_in;
   logic                     lvalid_ff, lvalid_in;
   logic                     ldirty_ff, ldirty_in;
   logic [AGE_BITS-1:0]      lage_ff, lage_in;
   logic [OUT_TAG_BITS-1:0]  ltag_ff, ltag_in;

   logic                  rd_en, wr_en;
   logic [INDEX_BITS-1:0] rd_addr, wr_addr;
   entry_type             rd_entry, wr_entry;
   logic [ENTRY_BITS-1:0] rd_word;

   logic                  cur_valid;
   entry_type             cur_entry;
   logic                  scan_last;
   logic [ADDR_BITS-1:0]  cur_page;
   logic [ADDR_BITS-1:0]  scan_page;

   // tag, dirty and age of every line
   wctag_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);

   // a line that is not valid reads as all zero
   assign cur_valid = valid_ff[item_ff.line];
   assign cur_entry = cur_valid ? rd_entry : entry_type'('0);
   assign cur_page  = {cur_entry.tag, item_ff.line};
   assign scan_page = {rd_entry.tag, scan_ff};
   assign scan_last = (scan_ff == {INDEX_BITS{1'b1}});

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      scan_in      = scan_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      victim_in    = victim_ff;
      vdirty_in    = vdirty_ff;
      lvalid_in    = lvalid_ff;
      ldirty_in    = ldirty_ff;
      lage_in      = lage_ff;
      ltag_in      = ltag_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head.line;
      wr_en        = 1'b0;
      wr_addr      = item_ff.line;
      wr_entry     = cur_entry;

      case (state_ff)
         // take the next request and start its line read or its flush walk
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop     = 1'b1;
               item_in = head;
               if (head.kind == KIND_FLUSH) begin
                  scan_in  = '0;
                  state_in = ST_FLUSH_SCAN;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end

         // read-modify-write of one line
         ST_EXEC: begin
            status_in = STATUS_MISS;
            victim_in = '0;
            vdirty_in = 1'b0;
            lvalid_in = cur_valid;
            case (item_ff.kind)
               KIND_READ, KIND_WRITE: begin
                  if (cur_valid && cur_entry.tag == item_ff.tag) begin
                     status_in = STATUS_HIT;
                     if (item_ff.kind == KIND_WRITE) begin
                        wr_entry.dirty = 1'b1;
                        wr_en          = 1'b1;
                     end
                  end
               end
               KIND_FILL: begin
                  status_in = STATUS_HIT;
                  if (cur_valid) begin
                     status_in = STATUS_WRITEBACK;
                     victim_in = OUT_ADDR_BITS'(cur_page);
                     vdirty_in = cur_entry.dirty;
                  end
                  wr_entry.tag   = item_ff.tag;
                  wr_entry.dirty = item_ff.fill_dirty;
                  wr_entry.age   = item_ff.fill_age;
                  wr_en          = 1'b1;
                  valid_in[item_ff.line] = 1'b1;
                  lvalid_in      = 1'b1;
               end
               KIND_AGE: begin
                  status_in = STATUS_HIT;
                  if (cur_entry.age != '0) begin
                     wr_entry.age = cur_entry.age - AGE_BITS'(1);
                  end
                  wr_en = cur_valid;
               end
               default: begin
                  status_in = STATUS_MISS;
               end
            endcase
            ldirty_in    = wr_entry.dirty;
            lage_in      = wr_entry.age;
            ltag_in      = OUT_TAG_BITS'(wr_entry.tag);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         // flush walk: skip empty lines, read valid ones
         ST_FLUSH_SCAN: begin
            rd_addr = scan_ff;
            if (valid_ff[scan_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_FLUSH_CHECK;
            end else if (scan_last) begin
               status_in    = STATUS_MISS;
               victim_in    = '0;
               vdirty_in    = 1'b0;
               lvalid_in    = 1'b0;
               ldirty_in    = 1'b0;
               lage_in      = '0;
               ltag_in      = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               scan_in = scan_ff + INDEX_BITS'(1);
            end
         end

         // flush walk: clear the line, stop on the first dirty one
         ST_FLUSH_CHECK: begin
            valid_in[scan_ff] = 1'b0;
            status_in = STATUS_MISS;
            victim_in = '0;
            vdirty_in = 1'b0;
            lvalid_in = 1'b0;
            ldirty_in = 1'b0;
            lage_in   = '0;
            ltag_in   = '0;
            if (rd_entry.dirty) begin
               status_in    = STATUS_HIT;
               victim_in    = OUT_ADDR_BITS'(scan_page);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               scan_in  = scan_ff + INDEX_BITS'(1);
               state_in = ST_FLUSH_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, valid bits and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      victim_ff <= victim_in;
      vdirty_ff <= vdirty_in;
      lvalid_ff <= lvalid_in;
      ldirty_ff <= ldirty_in;
      lage_ff   <= lage_in;
      ltag_ff   <= ltag_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_victim_page_address = victim_ff;
   assign rsp_victim_dirty        = vdirty_ff;
   assign rsp_line_valid          = lvalid_ff;
   assign rsp_line_dirty          = ldirty_ff;
   assign rsp_line_age            = lage_ff;
   assign rsp_line_tag            = ltag_ff;

   // checks
   `ASSERT_NEXT(a_rsp_single_cycle, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_IMPLIES(a_write_only_in_exec, clock, reset, wr_en, state_ff == ST_EXEC)
   `ASSERT_NEXT(a_fill_leaves_valid, clock, reset, state_ff == ST_EXEC && item_ff.kind == KIND_FILL, rsp_valid_ff && rsp_line_valid)

endmodule

FILE: src/writeback_cache_way_tag_store.sv
// ----------------------------------------------------------------------------
// writeback_cache_way_tag_store
// tag store for one way of a write-back cache: front classifies requests,
// a short queue decouples it from the back end that owns the tag memory
// ----------------------------------------------------------------------------
// lookup, fill, age: the request goes through the queue, the idle state with the
// tag ram read and the exec state, which registers the result strobe;
// the back end takes no new request before that read-modify-write is done. flush:
// the scan state for an empty line, scan and check for a valid one. busy rises only
// when the 2-entry queue is full; results cannot be stalled. reset clears all valid
// bits at once (no clearing pass), restores offset_bits to 6 and counter_bits to 2
module writeback_cache_way_tag_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [wctag_pkg::OP_BITS-1:0]         req_operation,
   input  logic [wctag_pkg::IN_ADDR_BITS-1:0]    req_address,
   input  logic                                  req_fill_dirty,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wctag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wctag_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                  rsp_valid,
   output logic [wctag_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [wctag_pkg::OUT_ADDR_BITS-1:0]   rsp_victim_page_address,
   output logic                                  rsp_victim_dirty,
   output logic                                  rsp_line_valid,
   output logic                                  rsp_line_dirty,
   output logic [wctag_pkg::AGE_BITS-1:0]        rsp_line_age,
   output logic [wctag_pkg::OUT_TAG_BITS-1:0]    rsp_line_tag
);
   import wctag_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         head;

   // request intake and configuration
   wctag_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_fill_dirty (req_fill_dirty),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   // decoupling queue
   wctag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   // execution against the tag memory
   wctag_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .head                    (head),
      .q_status                (q_status),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_victim_page_address (rsp_victim_page_address),
      .rsp_victim_dirty        (rsp_victim_dirty),
      .rsp_line_valid          (rsp_line_valid),
      .rsp_line_dirty          (rsp_line_dirty),
      .rsp_line_age            (rsp_line_age),
      .rsp_line_tag            (rsp_line_tag)
   );

endmodule

FILE: sim/way_tag_checker.sv
// ----------------------------------------------------------------------------
// way_tag_checker
// watches the request, result and register channels of the way tag store,
// keeps its own copy of the tag array and compares every result in order
// ----------------------------------------------------------------------------
module way_tag_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [wctag_pkg::OP_BITS-1:0]        req_operation,
   input  logic [wctag_pkg::IN_ADDR_BITS-1:0]   req_address,
   input  logic                                 req_fill_dirty,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [wctag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wctag_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                 rsp_valid,
   input  logic [wctag_pkg::STATUS_BITS-1:0]    rsp_status,
   input  logic [wctag_pkg::OUT_ADDR_BITS-1:0]  rsp_victim_page_address,
   input  logic                                 rsp_victim_dirty,
   input  logic                                 rsp_line_valid,
   input  logic                                 rsp_line_dirty,
   input  logic [wctag_pkg::AGE_BITS-1:0]       rsp_line_age,
   input  logic [wctag_pkg::OUT_TAG_BITS-1:0]   rsp_line_tag,
   output int                                   errors,
   output int                                   pending,
   output int                                   checked,
   output int                                   hits,
   output int                                   writebacks
);
   import wctag_pkg::*;

   // one result of the block
   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [OUT_ADDR_BITS-1:0] victim;
      logic                     victim_dirty;
      logic                     valid;
      logic                     dirty;
      logic [AGE_BITS-1:0]      age;
      logic [OUT_TAG_BITS-1:0]  tag;
   } line_report_type;

   // shadow copy of the tag array and the registers
   logic [TAG_BITS-1:0] line_tags  [LINES];
   bit                  line_valid [LINES];
   bit                  line_dirty [LINES];
   logic [AGE_BITS-1:0] line_ages  [LINES];
   logic [OFFSET_BITS-1:0] offset_cfg = OFFSET_RESET;
   logic [CNT_BITS-1:0]    counter_cfg = COUNTER_RESET;

   line_report_type awaited_reports[$];

   function automatic void clear_line(input int i);
      line_tags[i]  = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_ages[i]  = '0;
   endfunction

   // apply one request to the shadow array and return the result it must give
   function automatic line_report_type step_tag_store(input logic [OP_BITS-1:0] op,
                                                      input logic [IN_ADDR_BITS-1:0] addr,
                                                      input logic fill_dirty);
      line_report_type r;
      logic [INDEX_BITS-1:0] ln;
      logic [TAG_BITS-1:0] tg;
      int cb;
      r = '0;
      r.status = STATUS_MISS;
      ln = addr[INDEX_BITS-1:0];
      case (op)
         OP_READ, OP_WRITE: begin
            // byte address: offset below, then index, then tag
            tg = TAG_BITS'(addr >> (int'(offset_cfg) + INDEX_BITS));
            ln = INDEX_BITS'(addr >> offset_cfg);
            if (line_valid[ln] && line_tags[ln] == tg) begin
               r.status = STATUS_HIT;
               if (op == OP_WRITE) line_dirty[ln] = 1'b1;
            end
         end
         OP_FILL: begin
            cb = (counter_cfg > CNT_MAX) ? int'(CNT_MAX) : int'(counter_cfg);
            r.status = STATUS_HIT;
            if (line_valid[ln]) begin
               r.victim = {line_tags[ln], ln};
               r.victim_dirty = line_dirty[ln];
               r.status = STATUS_WRITEBACK;
            end
            line_tags[ln]  = addr[IN_ADDR_BITS-1:INDEX_BITS];
            line_valid[ln] = 1'b1;
            line_dirty[ln] = fill_dirty;
            line_ages[ln]  = AGE_BITS'((1 << cb) - 1);
         end
         OP_FLUSH: begin
            // clear from line 0 up to and including the first valid dirty line
            for (int i = 0; i < LINES; i++) begin
               if (line_valid[i] && line_dirty[i]) begin
                  r.victim = {line_tags[i], INDEX_BITS'(i)};
                  r.status = STATUS_HIT;
                  clear_line(i);
                  break;
               end
               clear_line(i);
            end
         end
         OP_AGE: begin
            if (line_ages[ln] != 0) line_ages[ln] = line_ages[ln] - 1'b1;
            r.status = STATUS_HIT;
         end
         default: ;
      endcase
      // flushed line reads back as all zero
      if (op != OP_FLUSH) begin
         r.valid = line_valid[ln];
         r.dirty = line_dirty[ln];
         r.age   = line_ages[ln];
         r.tag   = line_tags[ln];
      end
      return r;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      line_report_type want;
      if (reset) begin
         offset_cfg  = OFFSET_RESET;
         counter_cfg = COUNTER_RESET;
         for (int i = 0; i < LINES; i++) clear_line(i);
         awaited_reports.delete();
      end else begin
         // results first: a request taken at this edge cannot answer at it
         if (rsp_valid) begin
            if (awaited_reports.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, expected nothing, actual status %0h",
                        $time, rsp_status);
            end else begin
               want = awaited_reports.pop_front();
               checked++;
               if (want.status == STATUS_HIT) hits++;
               if (want.status == STATUS_WRITEBACK) writebacks++;
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("victim_page_address", want.victim, rsp_victim_page_address);
               compare_field("victim_dirty", 32'(want.victim_dirty), 32'(rsp_victim_dirty));
               compare_field("line_valid", 32'(want.valid), 32'(rsp_line_valid));
               compare_field("line_dirty", 32'(want.dirty), 32'(rsp_line_dirty));
               compare_field("line_age", 32'(want.age), 32'(rsp_line_age));
               compare_field("line_tag", 32'(want.tag), 32'(rsp_line_tag));
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OFFSET_BITS:  offset_cfg  = csr_wdata[OFFSET_BITS-1:0];
               CSR_COUNTER_BITS: counter_cfg = csr_wdata[CNT_BITS-1:0];
               default: ;
            endcase
         end
         // accepted request
         if (start && !busy)
            awaited_reports.push_back(step_tag_store(req_operation, req_address,
                                                     req_fill_dirty));
      end
      pending = awaited_reports.size();
   end

endmodule

FILE: sim/tb_writeback_cache_way_tag_store.sv
// ----------------------------------------------------------------------------
// tb_writeback_cache_way_tag_store
// drives directed and random requests into the way tag store under several
// register settings, with bursty request timing; a checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
module tb_writeback_cache_way_tag_store;
   import wctag_pkg::*;

   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int POOL_DEPTH       = 24;
   localparam int TAIL_CYCLES      = 600;
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = CSR_INDEX_BITS'(3);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_BITS-1:0]        req_operation  = OP_READ;
   logic [IN_ADDR_BITS-1:0]   req_address    = '0;
   logic                      req_fill_dirty = 1'b0;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index      = CSR_OFFSET_BITS;
   logic [CSR_DATA_BITS-1:0]  csr_wdata      = '0;
   logic                      rsp_valid;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [OUT_ADDR_BITS-1:0]  rsp_victim_page_address;
   logic                      rsp_victim_dirty;
   logic                      rsp_line_valid;
   logic                      rsp_line_dirty;
   logic [AGE_BITS-1:0]       rsp_line_age;
   logic [OUT_TAG_BITS-1:0]   rsp_line_tag;

   int errors;
   int pending;
   int checked;
   int hits;
   int writebacks;

   int cycles = 0;
   int burst_left = 0;
   int unsigned cur_offset = OFFSET_RESET;
   logic [IN_ADDR_BITS-1:0] resident_pages[$];
   int unsigned phase_offset  [PHASES] = '{0, 16, 31, 12, 3, 24};
   int unsigned phase_counter [PHASES] = '{0, 4, 7, 5, 1, 3};

   writeback_cache_way_tag_store dut (.*);
   way_tag_checker tag_check (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // tag bits a byte address can still reach under the current offset
   function automatic logic [IN_ADDR_BITS-1:0] reachable_tag_mask();
      return (cur_offset >= TAG_BITS) ? '0 : (32'hFF_FFFF >> cur_offset);
   endfunction

   function automatic logic [IN_ADDR_BITS-1:0] fresh_page();
      return {TAG_BITS'($urandom & reachable_tag_mask()), INDEX_BITS'($urandom)};
   endfunction

   // byte address inside a page, random offset bits
   function automatic logic [IN_ADDR_BITS-1:0] byte_of(input logic [IN_ADDR_BITS-1:0] page);
      logic [63:0] wide;
      wide = ({32'h0, page} << cur_offset) | (64'($urandom) & ((64'd1 << cur_offset) - 1));
      return wide[IN_ADDR_BITS-1:0];
   endfunction

   // one request, with a random gap at the start of each burst
   task automatic issue(input logic [OP_BITS-1:0] op, input logic [IN_ADDR_BITS-1:0] addr,
                        input logic fd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      req_fill_dirty <= fd;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // register writes while idle, random upper data bits
   task automatic set_config(input int unsigned off, input int unsigned cnt, input bit spare);
      csr_valid <= 1'b1;
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= {(CSR_DATA_BITS-OFFSET_BITS)'($urandom), OFFSET_BITS'(off)};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_COUNTER_BITS;
      csr_wdata <= {(CSR_DATA_BITS-CNT_BITS)'($urandom), CNT_BITS'(cnt)};
      do @(posedge clock); while (!csr_ready);
      if (spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= CSR_DATA_BITS'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cur_offset = off;
   endtask

   // mostly lookups on installed pages, some evictions, flushes and noise
   task automatic random_request();
      int pick;
      logic [IN_ADDR_BITS-1:0] page;
      pick = $urandom_range(0, 99);
      if (resident_pages.size() != 0 && $urandom_range(0, 3) != 0)
         page = resident_pages[$urandom_range(0, resident_pages.size() - 1)];
      else
         page = fresh_page();
      if (pick < 30) begin
         // half the fills hit a known line with a new tag to force an eviction
         if ($urandom_range(0, 1) == 1)
            page[IN_ADDR_BITS-1:INDEX_BITS] = TAG_BITS'(fresh_page() >> INDEX_BITS);
         issue(OP_FILL, page, 1'($urandom));
         resident_pages.push_back(page);
         if (resident_pages.size() > POOL_DEPTH) void'(resident_pages.pop_front());
      end else if (pick < 55) begin
         issue(OP_READ, byte_of(page), 1'($urandom));
      end else if (pick < 75) begin
         issue(OP_WRITE, byte_of(page), 1'($urandom));
      end else if (pick < 88) begin
         issue(OP_AGE, page, 1'($urandom));
      end else if (pick < 91) begin
         issue(OP_FLUSH, $urandom, 1'($urandom));
      end else begin
         issue(OP_BITS'($urandom), $urandom, 1'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset settings
      issue(OP_READ, 32'h0000_0000, 1'b1);          // empty line misses
      issue(OP_AGE, 32'h0000_0000, 1'b0);           // age already at zero
      issue(OP_FILL, 32'h0000_0105, 1'b0);          // fill into empty line
      issue(OP_READ, byte_of(32'h0000_0105), 1'b0);
      issue(OP_WRITE, byte_of(32'h0000_0105), 1'b0); // write hit sets dirty
      issue(OP_WRITE, byte_of(32'h0000_0205), 1'b1); // tag mismatch
      repeat (4) issue(OP_AGE, 32'hFFFF_FF05, 1'b0); // count down and saturate
      issue(OP_FILL, 32'h0000_0305, 1'b1);          // dirty victim written back
      issue(OP_FILL, 32'hFFFF_FFFF, 1'b1);          // top line, all-ones tag
      issue(OP_READ, 32'hFFFF_FFFF, 1'b1);
      issue(OP_FILL, 32'h0000_00FF, 1'b0);          // evicts all-ones page
      for (int op = OP_AGE + 1; op < (1 << OP_BITS); op++)
         issue(OP_BITS'(op), 32'hFFFF_FFFF, 1'b1);  // undefined operations
      issue(OP_FLUSH, 32'h0000_0000, 1'b0);         // finds the dirty line
      issue(OP_FLUSH, 32'hFFFF_FFFF, 1'b1);         // nothing dirty, whole sweep
      issue(OP_FILL, 32'h0000_0000, 1'b1);
      issue(OP_FLUSH, 32'h0000_0000, 1'b0);         // dirty line zero
      drain();

      // random part over several register settings
      for (int p = 0; p < PHASES; p++) begin
         set_config(phase_offset[p], phase_counter[p], p == 0);
         repeat (RANDOM_PER_PHASE) random_request();
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d results: %0d hits, %0d write-backs, %0d register settings",
               checked, hits, writebacks, PHASES + 1);
      if (errors == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
